[src/rwfs_pkg.sv]
// Package for the roulette-wheel fitness selector.
// Holds field widths, codes, the controller state type and the structs
// shared by the top level and the selection cells. No dependencies.
package rwfs_pkg;

    localparam int POP_MAX_DEF = 64;

    localparam int SCORE_W = 32;
    localparam int FRAC_W  = 32;
    localparam int SUM_W   = 40;
    localparam int FIT_W   = 32;
    localparam int FLOOR_W = 16;
    localparam int IDX_W   = 6;
    localparam int ZCNT_W  = 7;

    // 0.9 as 58982/65536
    localparam int SCALE_W     = 18;
    localparam int SCALE_SHIFT = 16;
    localparam logic signed [SCALE_W-1:0] SCALE_NUM = 18'sd58982;
    localparam int PROD_W = SCORE_W + SCALE_W;

    localparam logic [FLOOR_W-1:0] ZERO_FLOOR_RST = 16'd1;
    localparam logic signed [SCORE_W-1:0] SCORE_POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_NEG_MAX = 32'sh8000_0000;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_SELECT   = 1'b1;
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_SELECT  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_THR_MUL,
        ST_THR_SEL,
        ST_FIT,
        ST_SEL_ADD,
        ST_LAUNCH,
        ST_WALK,
        ST_EMIT
    } state_t;

    // Token that walks the row of cells, one cell per cycle.
    // acc is the running prefix sum on a close pass and the scaled random
    // value on a select pass.
    typedef struct packed {
        logic                      valid;
        logic                      kind;
        logic [SUM_W-1:0]          acc;
        logic                      found;
        logic [IDX_W-1:0]          sel_idx;
        logic signed [SCORE_W-1:0] best_score;
        logic [IDX_W-1:0]          best_idx;
        logic [ZCNT_W-1:0]         zeros;
    } wave_t;

    // Broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic                      wr_en;
        logic signed [SCORE_W-1:0] wr_score;
        logic                      fit_en;
        logic signed [SCORE_W-1:0] thr;
        logic [FLOOR_W-1:0]        zero_floor;
    } cell_ctrl_t;

endpackage

[src/roulette_wheel_fitness_selector_unit.sv]
// Roulette-wheel fitness selector: top level with sequencer and row of cells.
// Depends on rwfs_pkg and rwfs_cell.
//
// Scores are loaded one per cycle while the sequencer is idle into a row of
// POP_MAX cells; the load flagged last closes the population and returns a
// summary, and a select returns its answer. Both results come from a token
// that walks the row one cell per cycle, building the prefix sums on a close
// and finding the first prefix above the scaled random value on a select;
// ahead of the walk come the threshold multiply and the fitness update on a
// close, and the split random-by-total multiply on a select. One item is in
// work at a time; loads without the last flag are taken while an earlier
// result still waits.
module roulette_wheel_fitness_selector_unit import rwfs_pkg::*; #(
    parameter int POP_MAX = POP_MAX_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [FLOOR_W-1:0]        cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic signed [SCORE_W-1:0] s_score,
    input  logic                      s_last_score,
    input  logic [FRAC_W-1:0]         s_random_fraction,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_result_kind,
    output logic [IDX_W-1:0]          m_selected_index,
    output logic [IDX_W-1:0]          m_best_index,
    output logic signed [SCORE_W-1:0] m_best_score,
    output logic [ZCNT_W-1:0]         m_zero_count,
    output logic                      m_total_zero_error
);

    localparam int AW = $clog2(POP_MAX);
    localparam int CW = $clog2(POP_MAX + 1);

    state_t state_reg, state_next;

    logic [FLOOR_W-1:0]        zero_floor_reg;
    logic [CW-1:0]             loaded_count_reg;
    logic signed [SCORE_W-1:0] min_reg;
    logic signed [SCORE_W-1:0] max_reg;
    logic [CW-1:0]             pop_count_reg;

    logic [SUM_W-1:0]          fitness_total_reg;
    logic [IDX_W-1:0]          sum_best_idx_reg;
    logic signed [SCORE_W-1:0] sum_best_score_reg;
    logic [ZCNT_W-1:0]         sum_zeros_reg;
    logic                      sum_err_reg;

    logic signed [PROD_W-1:0]  thr_prod_reg;
    logic signed [SCORE_W-1:0] thr_min_reg;
    logic                      thr_eq_reg;
    logic signed [SCORE_W-1:0] thr_reg;
    logic signed [SCORE_W-1:0] thr_scaled;

    logic [FRAC_W+FRAC_W-1:0]  plo_reg;
    logic [SUM_W-1:0]          phi_reg;
    logic [SUM_W-1:0]          hi_reg;
    logic                      wave_kind_reg;

    logic                      res_kind_reg;
    logic [IDX_W-1:0]          res_sel_reg;
    logic [IDX_W-1:0]          fallback_idx;
    logic [CW-1:0]             pop_last;

    logic                      m_valid_reg;
    logic                      m_kind_reg;
    logic [IDX_W-1:0]          m_sel_reg;
    logic [IDX_W-1:0]          m_best_idx_reg;
    logic signed [SCORE_W-1:0] m_best_score_reg;
    logic [ZCNT_W-1:0]         m_zeros_reg;
    logic                      m_err_reg;

    logic s_fire;
    logic load_fire;
    logic load_store;
    logic sel_fire;
    logic inject;
    logic capture;
    logic emit_load;

    cell_ctrl_t          ctrl;
    wave_t               chain [0:POP_MAX];
    wave_t               tail;
    logic [POP_MAX-1:0]  wave_valid;

    assign s_fire     = s_valid && s_ready;
    assign load_fire  = s_fire && (s_req_type == REQ_LOAD);
    assign sel_fire   = s_fire && (s_req_type == REQ_SELECT);
    assign load_store = load_fire && (loaded_count_reg < CW'(POP_MAX));
    assign tail       = chain[POP_MAX];

    // Sequencer
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        inject     = 1'b0;
        capture    = 1'b0;
        emit_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_req_type == REQ_SELECT) begin
                        state_next = ST_SEL_ADD;
                    end else if (s_last_score) begin
                        state_next = ST_THR_MUL;
                    end
                end
            end
            ST_THR_MUL: begin
                state_next = ST_THR_SEL;
            end
            ST_THR_SEL: begin
                state_next = ST_FIT;
            end
            ST_FIT: begin
                state_next = ST_LAUNCH;
            end
            ST_SEL_ADD: begin
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                inject     = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (tail.valid) begin
                    capture    = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    emit_load  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration, load bookkeeping and closed-population summary
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_floor_reg     <= ZERO_FLOOR_RST;
            loaded_count_reg   <= '0;
            min_reg            <= SCORE_POS_MAX;
            max_reg            <= SCORE_NEG_MAX;
            pop_count_reg      <= '0;
            fitness_total_reg  <= '0;
            sum_best_idx_reg   <= '0;
            sum_best_score_reg <= '0;
            sum_zeros_reg      <= '0;
            sum_err_reg        <= 1'b1;
        end else begin
            if (cfg_we) begin
                zero_floor_reg <= cfg_wdata;
            end
            if (load_store) begin
                loaded_count_reg <= loaded_count_reg + 1'b1;
                if (s_score < min_reg) begin
                    min_reg <= s_score;
                end
                if (s_score > max_reg) begin
                    max_reg <= s_score;
                end
            end
            if (state_reg == ST_THR_MUL) begin
                pop_count_reg    <= loaded_count_reg;
                loaded_count_reg <= '0;
                min_reg          <= SCORE_POS_MAX;
                max_reg          <= SCORE_NEG_MAX;
            end
            if (capture && (tail.kind == KIND_SUMMARY)) begin
                fitness_total_reg  <= tail.acc;
                sum_best_idx_reg   <= tail.best_idx;
                sum_best_score_reg <= tail.best_score;
                sum_zeros_reg      <= tail.zeros;
                sum_err_reg        <= (tail.acc == '0);
            end
        end
    end

    // floor(x * 0.9) is an arithmetic shift of the product
    assign thr_scaled = thr_prod_reg[SCORE_W+SCALE_SHIFT-1:SCALE_SHIFT];

    assign pop_last     = pop_count_reg - 1'b1;
    assign fallback_idx = (pop_count_reg == '0) ? '0 : IDX_W'(pop_last);

    // Arithmetic ahead of the wave, and the wave's result
    always_ff @(posedge aclk) begin
        if (state_reg == ST_THR_MUL) begin
            thr_prod_reg <= ((min_reg == max_reg) ? min_reg : max_reg) * SCALE_NUM;
            thr_min_reg  <= min_reg;
            thr_eq_reg   <= (min_reg == max_reg);
        end
        if (state_reg == ST_THR_SEL) begin
            if (!thr_eq_reg && (thr_scaled < thr_min_reg)) begin
                thr_reg <= thr_min_reg;
            end else begin
                thr_reg <= thr_scaled;
            end
        end
        if (s_fire) begin
            wave_kind_reg <= sel_fire ? KIND_SELECT : KIND_SUMMARY;
        end
        // random * total split into low and high partial products
        if (sel_fire) begin
            plo_reg <= s_random_fraction * fitness_total_reg[FRAC_W-1:0];
            phi_reg <= SUM_W'(s_random_fraction * fitness_total_reg[SUM_W-1:FRAC_W]);
        end
        if (state_reg == ST_SEL_ADD) begin
            hi_reg <= phi_reg + {{(SUM_W - FRAC_W){1'b0}}, plo_reg[2*FRAC_W-1:FRAC_W]};
        end
        if (capture) begin
            res_kind_reg <= tail.kind;
            if (tail.kind == KIND_SELECT) begin
                res_sel_reg <= tail.found ? tail.sel_idx : fallback_idx;
            end else begin
                res_sel_reg <= '0;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_kind_reg       <= res_kind_reg;
            m_sel_reg        <= res_sel_reg;
            m_best_idx_reg   <= sum_best_idx_reg;
            m_best_score_reg <= sum_best_score_reg;
            m_zeros_reg      <= sum_zeros_reg;
            m_err_reg        <= sum_err_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_result_kind      = m_kind_reg;
    assign m_selected_index   = m_sel_reg;
    assign m_best_index       = m_best_idx_reg;
    assign m_best_score       = m_best_score_reg;
    assign m_zero_count       = m_zeros_reg;
    assign m_total_zero_error = m_err_reg;

    // Cell controls and the head of the row
    always_comb begin
        ctrl.wr_en      = load_store;
        ctrl.wr_score   = s_score;
        ctrl.fit_en     = (state_reg == ST_FIT);
        ctrl.thr        = thr_reg;
        ctrl.zero_floor = zero_floor_reg;
    end

    always_comb begin
        chain[0].valid      = inject;
        chain[0].kind       = wave_kind_reg;
        chain[0].acc        = (wave_kind_reg == KIND_SELECT) ? hi_reg : '0;
        chain[0].found      = 1'b0;
        chain[0].sel_idx    = '0;
        chain[0].best_score = SCORE_NEG_MAX;
        chain[0].best_idx   = '0;
        chain[0].zeros      = '0;
    end

    for (genvar i = 0; i < POP_MAX; i++) begin : g_cell
        rwfs_cell #(
            .POP_MAX (POP_MAX),
            .IDX     (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .wr_idx    (loaded_count_reg[AW-1:0]),
            .pop_count (pop_count_reg),
            .wave_in   (chain[i]),
            .wave_out  (chain[i+1])
        );
        assign wave_valid[i] = chain[i+1].valid;
    end

    // The token only reaches the end of the row while the sequencer waits for it
    a_tail_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        tail.valid |-> (state_reg == ST_WALK))
        else $error("wave token left the row outside the walk state");

    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(wave_valid) <= 1)
        else $error("more than one wave token in the row");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_count_reg <= CW'(POP_MAX))
        else $error("load count beyond population size");

    a_err_matches_total: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_err_reg == (fitness_total_reg == '0))
        else $error("zero-total flag disagrees with stored total");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && !m_valid_reg) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("result not moved into an empty output register");

endmodule

[src/rwfs_cell.sv]
// One member slot of the selector: raw score, shifted fitness and prefix sum.
// Updates the passing wave token and hands it to the next cell.
// Depends on rwfs_pkg.
module rwfs_cell import rwfs_pkg::*; #(
    parameter int POP_MAX = POP_MAX_DEF,
    parameter int IDX     = 0
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  cell_ctrl_t                         ctrl,
    input  logic [$clog2(POP_MAX)-1:0]         wr_idx,
    input  logic [$clog2(POP_MAX+1)-1:0]       pop_count,
    input  wave_t                              wave_in,
    output wave_t                              wave_out
);

    localparam int AW = $clog2(POP_MAX);
    localparam int CW = $clog2(POP_MAX + 1);

    logic signed [SCORE_W-1:0] score_reg;
    logic [FIT_W-1:0]          fit_reg;
    logic                      zero_reg;
    logic [SUM_W-1:0]          prefix_reg;
    wave_t                     wave_reg;
    wave_t                     wave_next;

    logic                      active;
    logic                      hit;
    logic signed [SCORE_W:0]   shifted;
    logic                      below_floor;
    logic [SUM_W:0]            sum_raw;
    logic [SUM_W-1:0]          sum_sat;

    assign active = CW'(IDX) < pop_count;
    assign hit    = ctrl.wr_en && (wr_idx == AW'(IDX));

    assign shifted     = {score_reg[SCORE_W-1], score_reg} - {ctrl.thr[SCORE_W-1], ctrl.thr};
    assign below_floor = shifted < $signed({{(SCORE_W + 1 - FLOOR_W){1'b0}}, ctrl.zero_floor});

    assign sum_raw = {1'b0, wave_in.acc} + {{(SUM_W + 1 - FIT_W){1'b0}}, fit_reg};
    assign sum_sat = sum_raw[SUM_W] ? SUM_MAX : sum_raw[SUM_W-1:0];

    always_comb begin
        wave_next = wave_in;
        if (wave_in.valid && active) begin
            case (wave_in.kind)
                KIND_SUMMARY: begin
                    wave_next.acc   = sum_sat;
                    wave_next.zeros = wave_in.zeros + ZCNT_W'(zero_reg);
                    // strict compare keeps the first member on ties
                    if (score_reg > wave_in.best_score) begin
                        wave_next.best_score = score_reg;
                        wave_next.best_idx   = IDX_W'(IDX);
                    end
                end
                KIND_SELECT: begin
                    if (!wave_in.found && (wave_in.acc < prefix_reg)) begin
                        wave_next.found   = 1'b1;
                        wave_next.sel_idx = IDX_W'(IDX);
                    end
                end
                default: begin
                    wave_next = wave_in;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (hit) begin
            score_reg <= ctrl.wr_score;
        end
        if (ctrl.fit_en) begin
            zero_reg <= below_floor;
            fit_reg  <= below_floor ? '0 : shifted[FIT_W-1:0];
        end
        if (wave_in.valid && active && (wave_in.kind == KIND_SUMMARY)) begin
            prefix_reg <= sum_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_reg.valid <= 1'b0;
        end else begin
            wave_reg <= wave_next;
        end
    end

    assign wave_out = wave_reg;

endmodule
